FILE: src/psf_pkg.sv
// Shared types, constants and constant functions of the penetrative shortwave flux core.
package psf_pkg;

    localparam int TABLE_INDEX_BITS_DEF = 8;

    localparam int DEPTH_W  = 20;
    localparam int CHL_W    = 24;
    localparam int FLUX_W   = 19;
    localparam int STATUS_W = 2;

    localparam int C_W    = 20;
    localparam int ACC_W  = 32;
    localparam int V_W    = 24;
    localparam int EXP_W  = 40;
    localparam int TERM_W = 48;
    localparam int NPOLY  = 4;
    localparam int NCOEF  = 6;

    localparam int POLY_V1 = 0;
    localparam int POLY_V2 = 1;
    localparam int POLY_E1 = 2;
    localparam int POLY_E2 = 3;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_CHL_ZERO = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SAT      = 2'd2;

    localparam logic [FLUX_W-1:0] FLUX_MAX     = '1;
    localparam logic [15:0]       LOG10_2_Q16  = 16'd19728;
    localparam logic [16:0]       LOG2_E_Q16   = 17'd94548;
    localparam logic [14:0]       FRAC047_Q16  = 15'd30802;

    localparam logic signed [ACC_W-1:0] POLY_COEF [NPOLY][NCOEF] = '{
        '{ 32'sd21037,   32'sd524,     32'sd8651,   32'sd2490,    -32'sd1114,  -32'sd459 },
        '{ 32'sd44512,   -32'sd524,    -32'sd8651,  -32'sd2490,   32'sd1114,   32'sd459 },
        '{ 32'sd100925,  32'sd0,       -32'sd10879, -32'sd16515,  -32'sd3604,  32'sd2753 },
        '{ 32'sd519373,  -32'sd435421, 32'sd239993, -32'sd118948, -32'sd14287, 32'sd32899 }
    };

    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic [FLUX_W-1:0]  flux;
        logic               chl_zero;
    } psf_side_t;

    // Shift right by 16 with rounding half away from zero.
    function automatic logic signed [63:0] rshr16(input logic signed [63:0] v);
        logic [63:0] mag;
        mag = v[63] ? 64'(-v) : 64'(v);
        mag = (mag + 64'd32768) >> 16;
        return v[63] ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] xin);
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] b;
        x = xin;
        r = '0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (b > x) b = b >> 2;
        end
        for (int i = 0; i < 32; i++) begin
            if (b != 64'd0) begin
                if (x >= r + b) begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // Fractional log2 of the mantissa 1.idx, by repeated squaring in Q1.30.
    function automatic logic [15:0] log2_frac(input int idx, input int tib);
        logic [63:0] x;
        logic [15:0] frac;
        x = (64'd1 << 30) | (64'(idx) << (30 - tib));
        frac = '0;
        for (int i = 0; i < 16; i++) begin
            x = (x * x) >> 30;
            frac = {frac[14:0], 1'b0};
            if (x >= (64'd2 << 30)) begin
                frac[0] = 1'b1;
                x = x >> 1;
            end
        end
        return frac;
    endfunction

    // The i-th successive square root of 2 in Q1.30.
    function automatic logic [30:0] sqrt2_root(input int i);
        logic [63:0] r;
        r = 64'd2 << 30;
        for (int k = 0; k < i; k++) begin
            r = isqrt64(r << 30);
        end
        return r[30:0];
    endfunction

endpackage

FILE: src/psf_log2.sv
// Chlorophyll normalization, log2 table lookup and scaling to log10 in Q16.
module psf_log2 import psf_pkg::*; #(
    parameter int TABLE_INDEX_BITS = TABLE_INDEX_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  valid_i,
    input  logic [CHL_W-1:0]      chl_i,
    input  psf_side_t             side_i,
    output logic                  valid_o,
    output logic signed [C_W-1:0] c_o,
    output psf_side_t             side_o
);

    localparam int ROM_DEPTH = 2 ** TABLE_INDEX_BITS;

    logic [15:0] rom_tab [ROM_DEPTH];

    for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_rom
        assign rom_tab[g] = log2_frac(g, TABLE_INDEX_BITS);
    end

    logic [3:0]                  valid_reg;
    psf_side_t                   side_reg [4];
    logic [4:0]                  p_next;
    logic [CHL_W-1:0]            norm;
    logic [TABLE_INDEX_BITS-1:0] idx_next;
    logic [4:0]                  p1_reg, p2_reg;
    logic [TABLE_INDEX_BITS-1:0] idx_reg;
    logic [15:0]                 frac_reg;
    logic signed [5:0]           pm;
    logic signed [21:0]          l2;
    logic signed [38:0]          prod_reg;
    logic signed [63:0]          c_full;
    logic signed [C_W-1:0]       c_reg;

    always_comb begin
        p_next = '0;
        for (int i = 0; i < CHL_W; i++) begin
            if (chl_i[i]) p_next = 5'(i);
        end
        norm     = chl_i << (5'(CHL_W - 1) - p_next);
        idx_next = norm[CHL_W-2 -: TABLE_INDEX_BITS];
    end

    assign pm     = $signed({1'b0, p2_reg}) - 6'sd16;
    assign l2     = {pm, frac_reg};
    assign c_full = rshr16(64'(prod_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[2:0], valid_i};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side_i;
            side_reg[1] <= side_reg[0];
            side_reg[2] <= side_reg[1];
            side_reg[3] <= side_reg[2];
            p1_reg      <= p_next;
            idx_reg     <= idx_next;
            p2_reg      <= p1_reg;
            frac_reg    <= rom_tab[idx_reg];
            prod_reg    <= l2 * $signed({1'b0, LOG10_2_Q16});
            c_reg       <= c_full[C_W-1:0];
        end
    end

    assign valid_o = valid_reg[3];
    assign c_o     = c_reg;
    assign side_o  = side_reg[3];

endmodule

FILE: src/psf_poly.sv
// Four fifth-order polynomials in C, one Horner step per pipeline stage.
module psf_poly import psf_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    valid_i,
    input  logic signed [C_W-1:0]   c_i,
    input  psf_side_t               side_i,
    output logic                    valid_o,
    output logic signed [V_W-1:0]   v1_o,
    output logic signed [V_W-1:0]   v2_o,
    output logic signed [ACC_W-1:0] e1_o,
    output logic signed [ACC_W-1:0] e2_o,
    output psf_side_t               side_o
);

    localparam int NSTEP = NCOEF - 1;

    logic [NSTEP-1:0]        valid_reg;
    psf_side_t               side_reg [NSTEP];
    logic signed [C_W-1:0]   c_reg    [NSTEP];
    logic signed [ACC_W-1:0] acc_reg  [NSTEP][NPOLY];
    logic signed [ACC_W-1:0] acc_in   [NSTEP][NPOLY];
    logic signed [C_W-1:0]   c_in     [NSTEP];
    psf_side_t               side_in  [NSTEP];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[NSTEP-2:0], valid_i};
        end
    end

    for (genvar j = 0; j < NSTEP; j++) begin : g_step
        if (j == 0) begin : g_first
            assign c_in[j]    = c_i;
            assign side_in[j] = side_i;
            for (genvar l = 0; l < NPOLY; l++) begin : g_seed
                assign acc_in[j][l] = POLY_COEF[l][NCOEF-1];
            end
        end else begin : g_rest
            assign c_in[j]    = c_reg[j-1];
            assign side_in[j] = side_reg[j-1];
            for (genvar l = 0; l < NPOLY; l++) begin : g_link
                assign acc_in[j][l] = acc_reg[j-1][l];
            end
        end

        for (genvar l = 0; l < NPOLY; l++) begin : g_lane
            logic signed [ACC_W+C_W-1:0] prod;
            logic signed [63:0]          rnd;
            logic signed [ACC_W-1:0]     acc_next;

            assign prod     = acc_in[j][l] * c_in[j];
            assign rnd      = rshr16(64'(prod));
            assign acc_next = rnd[ACC_W-1:0] + POLY_COEF[l][NSTEP-1-j];

            always_ff @(posedge aclk) begin
                if (en) acc_reg[j][l] <= acc_next;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                c_reg[j]    <= c_in[j];
                side_reg[j] <= side_in[j];
            end
        end
    end

    assign valid_o = valid_reg[NSTEP-1];
    assign v1_o    = acc_reg[NSTEP-1][POLY_V1][V_W-1:0];
    assign v2_o    = acc_reg[NSTEP-1][POLY_V2][V_W-1:0];
    assign e1_o    = acc_reg[NSTEP-1][POLY_E1];
    assign e2_o    = acc_reg[NSTEP-1][POLY_E2];
    assign side_o  = side_reg[NSTEP-1];

endmodule

FILE: src/psf_band.sv
// One band: depth over attenuation divider, exponential and weighting.
module psf_band import psf_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     valid_i,
    input  logic [DEPTH_W-1:0]       depth_i,
    input  logic signed [ACC_W-1:0]  e_i,
    input  logic signed [V_W-1:0]    v_i,
    input  psf_side_t                side_i,
    output logic                     valid_o,
    output logic signed [TERM_W-1:0] term_o,
    output psf_side_t                side_o
);

    localparam int DIV_BITS = 20;
    localparam int NUM_W    = DEPTH_W + 24;
    localparam int CMP_W    = ACC_W + DIV_BITS;
    localparam int NROOT    = 16;
    localparam int LAT      = 1 + DIV_BITS + 1 + 1 + NROOT + 1 + 1 + 1;
    localparam int V_TAP    = LAT - 3;

    typedef struct packed {
        logic signed [V_W-1:0] v;
        psf_side_t             side;
    } band_carry_t;

    logic [LAT-1:0] valid_reg;
    band_carry_t    pipe_reg [LAT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[LAT-2:0], valid_i};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pipe_reg[0] <= '{v: v_i, side: side_i};
            for (int k = 1; k < LAT; k++) pipe_reg[k] <= pipe_reg[k-1];
        end
    end

    // Divider: magnitude of depth * 2^24 / e, limited to 2^20.
    logic [ACC_W-1:0]    ae_reg  [DIV_BITS+1];
    logic [NUM_W-1:0]    rem_reg [DIV_BITS+1];
    logic [DIV_BITS-1:0] q_reg   [DIV_BITS+1];
    logic                neg_reg [DIV_BITS+1];
    logic                sat_reg [DIV_BITS+1];
    logic [ACC_W-1:0]    ae_next;
    logic [NUM_W-1:0]    num_next;

    always_comb begin
        if (e_i == '0)     ae_next = ACC_W'(1);
        else if (e_i[ACC_W-1]) ae_next = ACC_W'(-e_i);
        else               ae_next = ACC_W'(e_i);
        num_next = {depth_i, 24'b0};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ae_reg[0]  <= ae_next;
            rem_reg[0] <= num_next;
            q_reg[0]   <= '0;
            neg_reg[0] <= e_i[ACC_W-1];
            sat_reg[0] <= CMP_W'(num_next) >= (CMP_W'(ae_next) << DIV_BITS);
        end
    end

    for (genvar j = 1; j <= DIV_BITS; j++) begin : g_div
        localparam int K = DIV_BITS - j;
        logic [CMP_W-1:0]    dsh;
        logic                take;
        logic [NUM_W-1:0]    rem_next;
        logic [DIV_BITS-1:0] q_next;

        always_comb begin
            dsh      = CMP_W'(ae_reg[j-1]) << K;
            take     = !sat_reg[j-1] && (CMP_W'(rem_reg[j-1]) >= dsh);
            rem_next = rem_reg[j-1];
            q_next   = q_reg[j-1];
            if (take) begin
                rem_next = rem_reg[j-1] - dsh[NUM_W-1:0];
                q_next[K] = 1'b1;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                ae_reg[j]  <= ae_reg[j-1];
                rem_reg[j] <= rem_next;
                q_reg[j]   <= q_next;
                neg_reg[j] <= neg_reg[j-1];
                sat_reg[j] <= sat_reg[j-1];
            end
        end
    end

    // Exponent argument in Q16 and its conversion to a power of two.
    logic [DIV_BITS:0]         qmag;
    logic signed [DIV_BITS+1:0] t_val;
    logic signed [DIV_BITS+18:0] tprod_reg;
    logic signed [63:0]        u_full;

    always_comb begin
        qmag  = sat_reg[DIV_BITS] ? (DIV_BITS+1)'(1) << DIV_BITS
                                  : {1'b0, q_reg[DIV_BITS]};
        t_val = neg_reg[DIV_BITS] ? $signed({1'b0, qmag}) : -$signed({1'b0, qmag});
    end

    assign u_full = rshr16(64'(tprod_reg));

    logic signed [7:0] xn_reg  [NROOT+1];
    logic [15:0]       xf_reg  [NROOT+1];
    logic [30:0]       xacc_reg [NROOT+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            tprod_reg   <= t_val * $signed({1'b0, LOG2_E_Q16});
            xn_reg[0]   <= u_full[23:16];
            xf_reg[0]   <= u_full[15:0];
            xacc_reg[0] <= 31'd1 << 30;
        end
    end

    for (genvar i = 1; i <= NROOT; i++) begin : g_root
        localparam logic [30:0] ROOT = sqrt2_root(i);
        logic [61:0] prod;
        logic [30:0] acc_next;

        assign prod     = xacc_reg[i-1] * ROOT;
        assign acc_next = xf_reg[i-1][NROOT-i] ? prod[60:30] : xacc_reg[i-1];

        always_ff @(posedge aclk) begin
            if (en) begin
                xacc_reg[i] <= acc_next;
                xn_reg[i]   <= xn_reg[i-1];
                xf_reg[i]   <= xf_reg[i-1];
            end
        end
    end

    // Integer part of the exponent, then the weight.
    logic [EXP_W-1:0]         exp_next;
    logic [EXP_W-1:0]         exp_reg;
    logic signed [V_W+20:0]   plo_reg, phi_reg;
    logic signed [63:0]       full;
    logic signed [63:0]       term_full;
    logic signed [TERM_W-1:0] term_reg;
    logic signed [V_W-1:0]    v_tap;

    always_comb begin
        if (xn_reg[NROOT] >= 8'sd14)
            exp_next = EXP_W'(xacc_reg[NROOT]) << 6'(xn_reg[NROOT] - 8'sd14);
        else
            exp_next = EXP_W'(xacc_reg[NROOT]) >> 6'(8'sd14 - xn_reg[NROOT]);
    end

    assign v_tap     = pipe_reg[V_TAP].v;
    assign full      = (64'(phi_reg) <<< 20) + 64'(plo_reg);
    assign term_full = rshr16(full);

    always_ff @(posedge aclk) begin
        if (en) begin
            exp_reg  <= exp_next;
            plo_reg  <= v_tap * $signed({1'b0, exp_reg[19:0]});
            phi_reg  <= v_tap * $signed({1'b0, exp_reg[EXP_W-1:20]});
            term_reg <= term_full[TERM_W-1:0];
        end
    end

    assign valid_o = valid_reg[LAT-1];
    assign term_o  = term_reg;
    assign side_o  = pipe_reg[LAT-1].side;

endmodule

FILE: src/psf_out.sv
// Sum of band terms, flux scaling, saturation and the output register.
module psf_out import psf_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     valid_i,
    input  logic signed [TERM_W-1:0] term1_i,
    input  logic signed [TERM_W-1:0] term2_i,
    input  psf_side_t                side_i,
    output logic                     valid_o,
    output logic [FLUX_W-1:0]        flux_o,
    output logic [STATUS_W-1:0]      status_o
);

    localparam int A_W = FLUX_W + 15;
    localparam int S_W = TERM_W;
    localparam int H_W = S_W / 2;
    localparam int P_W = A_W + S_W;
    localparam logic [P_W-1:0] SAT_LIM  = (P_W'(1) << 51) - (P_W'(1) << 31);
    localparam logic [P_W-1:0] HALF_LSB = P_W'(1) << 31;

    logic [2:0]                valid_reg;
    logic signed [TERM_W:0]    sum_reg;
    logic [A_W-1:0]            a1_reg;
    logic                      chl1_reg, swz1_reg, chl2_reg, swz2_reg;
    logic                      sumz_reg, sumn_reg;
    logic [A_W+H_W-1:0]        pl_reg, ph_reg;
    logic [S_W-1:0]            s_val;
    logic [P_W-1:0]            prod;
    logic [P_W-1:0]            rnd;
    logic [FLUX_W-1:0]         flux_next, flux_reg;
    logic [STATUS_W-1:0]       status_next, status_reg;

    assign s_val = sum_reg[S_W-1:0];
    assign prod  = (P_W'(ph_reg) << H_W) + P_W'(pl_reg);
    assign rnd   = (prod + HALF_LSB) >> 32;

    always_comb begin
        flux_next   = '0;
        status_next = STATUS_OK;
        if (chl2_reg) begin
            status_next = STATUS_CHL_ZERO;
        end else if (swz2_reg || sumz_reg) begin
            status_next = STATUS_OK;
        end else if (sumn_reg) begin
            status_next = STATUS_SAT;
        end else if (prod >= SAT_LIM) begin
            flux_next   = FLUX_MAX;
            status_next = STATUS_SAT;
        end else begin
            flux_next   = rnd[FLUX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[1:0], valid_i};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg    <= (TERM_W+1)'(term1_i) + (TERM_W+1)'(term2_i);
            a1_reg     <= side_i.flux * FRAC047_Q16;
            chl1_reg   <= side_i.chl_zero;
            swz1_reg   <= (side_i.flux == '0);
            pl_reg     <= a1_reg * s_val[H_W-1:0];
            ph_reg     <= a1_reg * s_val[S_W-1:H_W];
            sumz_reg   <= (sum_reg == '0);
            sumn_reg   <= sum_reg[TERM_W];
            chl2_reg   <= chl1_reg;
            swz2_reg   <= swz1_reg;
            flux_reg   <= flux_next;
            status_reg <= status_next;
        end
    end

    assign valid_o  = valid_reg[2];
    assign flux_o   = flux_reg;
    assign status_o = status_reg;

endmodule

FILE: src/penetrative_shortwave_flux_core.sv
// Top level of the pipelined two-band penetrative shortwave flux core.
//
//   Channel   Direction  Handshake           Payload
//   s_        in         s_tvalid/s_tready   s_tdata: layer_depth, chlorophyll, surface_flux
//   m_        out        m_tvalid/m_tready   m_tdata: penetrating_flux; m_tuser: status
//
// One word is accepted per clock while the pipeline is not held, and every word
// gives exactly one result word after the log2 stages, 5 Horner steps, the stages
// of each band (a 20 stage restoring divider and 16 root multiply stages among
// them) and the scaling stages that end in the output register.
// Reset (aresetn low at a rising edge) clears all valid bits; data registers
// keep whatever they hold. When a result waits in the output register and
// m_tready is low, the whole pipeline holds, so nothing is lost or repeated.
module penetrative_shortwave_flux_core import psf_pkg::*; #(
    parameter int TABLE_INDEX_BITS = TABLE_INDEX_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata fields from bit 0: layer_depth[19:0], chlorophyll[43:20],
    // surface_flux[62:44], zero pad [63]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,
    // m_tdata fields from bit 0: penetrating_flux[18:0], zero pad [23:19]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,
    // m_tuser fields from bit 0: status[1:0]
    output logic [1:0]  m_tuser
);

    // The pipeline advances whenever the output register is empty or draining.
    logic en;

    psf_side_t             side_in, side_l2, side_poly, side_b1;
    logic                  v_l2, v_poly, v_b1, v_b2;
    logic signed [C_W-1:0] c_val;
    logic signed [V_W-1:0]   v1, v2;
    logic signed [ACC_W-1:0] e1, e2;
    logic signed [TERM_W-1:0] term1, term2;
    logic [FLUX_W-1:0]     flux;
    logic [STATUS_W-1:0]   status;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    assign side_in.depth    = s_tdata[DEPTH_W-1:0];
    assign side_in.flux     = s_tdata[DEPTH_W+CHL_W +: FLUX_W];
    assign side_in.chl_zero = (s_tdata[DEPTH_W +: CHL_W] == '0);

    psf_log2 #(
        .TABLE_INDEX_BITS(TABLE_INDEX_BITS)
    ) u_log2 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .valid_i (s_tvalid),
        .chl_i   (s_tdata[DEPTH_W +: CHL_W]),
        .side_i  (side_in),
        .valid_o (v_l2),
        .c_o     (c_val),
        .side_o  (side_l2)
    );

    psf_poly u_poly (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .valid_i (v_l2),
        .c_i     (c_val),
        .side_i  (side_l2),
        .valid_o (v_poly),
        .v1_o    (v1),
        .v2_o    (v2),
        .e1_o    (e1),
        .e2_o    (e2),
        .side_o  (side_poly)
    );

    // Both bands run in lockstep; the first one carries the side data along.
    psf_band u_band1 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .valid_i (v_poly),
        .depth_i (side_poly.depth),
        .e_i     (e1),
        .v_i     (v1),
        .side_i  (side_poly),
        .valid_o (v_b1),
        .term_o  (term1),
        .side_o  (side_b1)
    );

    psf_band u_band2 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .valid_i (v_poly),
        .depth_i (side_poly.depth),
        .e_i     (e2),
        .v_i     (v2),
        .side_i  (side_poly),
        .valid_o (v_b2),
        .term_o  (term2),
        .side_o  ()
    );

    psf_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .valid_i  (v_b1 & v_b2),
        .term1_i  (term1),
        .term2_i  (term2),
        .side_i   (side_b1),
        .valid_o  (m_tvalid),
        .flux_o   (flux),
        .status_o (status)
    );

    assign m_tdata = {5'b0, flux};
    assign m_tuser = status;

endmodule
